// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the controller module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RDLM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define RDLM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition");

`endif

// ----- src/rdlm_pkg.sv -----
// ----------------------------------------------------------------------------
// RMS level meter package
// Constants, command/status types and the elaboration-time log2 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rdlm_pkg;

  localparam int DC_SAMPLES = 16;
  localparam int ADC_BITS   = 10;
  localparam int BAR_WIDTH  = 116;
  localparam int DB_FLOOR_MAG = 2144;
  localparam int BAR_LOW    = 480;
  // divide by 1440 as a shift by 5 and a reciprocal of 45 in Q.20
  localparam int BAR_PRE_SHIFT   = 5;
  localparam int BAR_RECIP       = 23302;
  localparam int BAR_RECIP_SHIFT = 20;
  localparam int DIV_STEPS  = 48;
  localparam int SQR_STEPS  = 24;
  localparam int NORM_TOP   = 27;
  localparam logic [29:0] LOG_K = 30'd808071242;
  localparam logic [15:0] WINDOW_RESET = 16'd600;

  localparam logic [1:0] REG_WINDOW      = 2'd0;
  localparam logic [1:0] REG_CALIB_OFFS  = 2'd1;
  localparam logic [1:0] REG_CALIB_VALID = 2'd2;

  localparam longint FULL_SCALE =
    (((longint'(1) << ADC_BITS) - 1) * DC_SAMPLES) *
    (((longint'(1) << ADC_BITS) - 1) * DC_SAMPLES);

  function automatic logic [63:0] log2_q24(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    logic [5:0]  n;
    n = '0;
    frac = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 6'(i);
    end
    if (n >= 6'd30) m = x >> (n - 6'd30);
    else m = x << (6'd30 - n);
    for (int j = 0; j < 24; j++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(n) << 24) | frac;
  endfunction

  localparam logic [28:0] LOG_FS = 29'(log2_q24(64'(FULL_SCALE)));

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_MS_LOAD,
    OP_DIV_STEP,
    OP_NORM_LOAD,
    OP_NORM_STEP,
    OP_SQR_STEP,
    OP_MAG,
    OP_MUL,
    OP_ROUND,
    OP_BAR_LOAD,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    logic in_ready;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic norm_done;
    logic sqr_done;
    logic bar_skip;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- src/rdlm_ctrl.sv -----
// ----------------------------------------------------------------------------
// RMS level meter controller
// Sequences sample intake and the end-of-window divide, log, bar and output steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rdlm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire rdlm_pkg::status_t status_i,
  output rdlm_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_RUN,
    S_MSDIV,
    S_DIV_MS,
    S_NORM_LD,
    S_NORM,
    S_SQR,
    S_MAG,
    S_MUL,
    S_RND,
    S_BAR_LD,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.in_ready = 1'b0;
    cmd_o.op = rdlm_pkg::OP_NONE;
    case (state_q)
      S_RUN: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = rdlm_pkg::OP_SAMPLE;
          if (status_i.last) state_d = S_MSDIV;
        end
      end
      S_MSDIV: begin
        cmd_o.op = rdlm_pkg::OP_MS_LOAD;
        state_d = S_DIV_MS;
      end
      S_DIV_MS: begin
        cmd_o.op = rdlm_pkg::OP_DIV_STEP;
        if (status_i.div_done) state_d = S_NORM_LD;
      end
      S_NORM_LD: begin
        cmd_o.op = rdlm_pkg::OP_NORM_LOAD;
        state_d = S_NORM;
      end
      S_NORM: begin
        cmd_o.op = rdlm_pkg::OP_NORM_STEP;
        if (status_i.norm_done) state_d = S_SQR;
      end
      S_SQR: begin
        cmd_o.op = rdlm_pkg::OP_SQR_STEP;
        if (status_i.sqr_done) state_d = S_MAG;
      end
      S_MAG: begin
        cmd_o.op = rdlm_pkg::OP_MAG;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = rdlm_pkg::OP_MUL;
        state_d = S_RND;
      end
      S_RND: begin
        cmd_o.op = rdlm_pkg::OP_ROUND;
        state_d = S_BAR_LD;
      end
      S_BAR_LD: begin
        cmd_o.op = rdlm_pkg::OP_BAR_LOAD;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = rdlm_pkg::OP_OUT_LOAD;
          state_d = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  `RDLM_ASSERT_NEVER(a_no_overwrite, cmd_o.op == rdlm_pkg::OP_OUT_LOAD && status_i.out_busy)
  `RDLM_ASSERT(a_last_ends_window,
               (cmd_o.op == rdlm_pkg::OP_SAMPLE && status_i.last) |=> state_q == S_MSDIV)
  `RDLM_ASSERT(a_sqr_to_mag, (state_q == S_SQR && status_i.sqr_done) |=> state_q == S_MAG)
  `RDLM_ASSERT_NEVER(a_busy_no_intake, cmd_o.op == rdlm_pkg::OP_SAMPLE && state_q != S_RUN)

endmodule

`default_nettype wire

// ----- src/rdlm_datapath.sv -----
// ----------------------------------------------------------------------------
// RMS level meter datapath
// DC and square accumulators, divider, log2 unit and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdlm_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rdlm_pkg::cmd_t     cmd_i,
  output rdlm_pkg::status_t       status_o,
  input  wire logic [9:0]         sample_i,
  input  wire logic [15:0]        window_i,
  input  wire logic signed [12:0] calib_offset_i,
  input  wire logic               calib_valid_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [12:0]      dbfs_level_o,
  output logic signed [13:0]      spl_level_o,
  output logic [6:0]              bar_fill_o,
  output logic                    calibrated_o,
  output logic [27:0]             mean_square_o
);

  logic [16:0] phase_q;
  logic [13:0] dc_q;
  logic [47:0] sq_q;
  logic [15:0] k_q;
  logic [5:0]  cnt_q;
  logic        out_valid_q;

  logic [16:0] rem_q;
  logic [47:0] quo_q;
  logic [15:0] dvs_q;
  logic [27:0] ms_q;
  logic [27:0] x_q;
  logic [4:0]  n_q;
  logic [30:0] m_q;
  logic [23:0] frac_q;
  logic [28:0] mag_q;
  logic [58:0] prod_q;
  logic signed [12:0] dbfs_q;
  logic signed [13:0] spl_q;

  logic              is_dc;
  logic [16:0]       phase_inc;
  logic [16:0]       k_next;
  logic signed [15:0] cen;
  logic signed [31:0] cen_sq;
  logic [16:0]       rem_sh;
  logic              rem_ge;
  logic [16:0]       rem_nx;
  logic [61:0]       mm;
  logic [31:0]       mt;
  logic [28:0]       lms;
  logic [59:0]       rnd;
  logic [11:0]       r;
  logic signed [12:0] dbfs_d;
  logic signed [13:0] spl_d;
  logic [13:0]       bar_d;
  logic [18:0]       bar_prod;
  logic [13:0]       bar_pre;
  logic [28:0]       bar_rcp;
  logic [6:0]        bar_val;

  assign is_dc     = phase_q < 17'(rdlm_pkg::DC_SAMPLES);
  assign phase_inc = phase_q + 17'd1;
  assign k_next    = phase_inc - 17'(rdlm_pkg::DC_SAMPLES);
  assign cen       = $signed({2'b00, sample_i, 4'b0000}) - $signed({2'b00, dc_q});
  assign cen_sq    = cen * cen;

  assign rem_sh = {rem_q[15:0], quo_q[47]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  assign mm  = 62'(m_q) * 62'(m_q);
  assign mt  = mm[61:30];
  assign lms = {n_q, frac_q};

  assign rnd = {1'b0, prod_q} + (60'd1 << 47);
  assign r   = rnd[59:48];
  assign dbfs_d = (ms_q == '0 || r > 12'(rdlm_pkg::DB_FLOOR_MAG)) ?
                  -13'sd2144 : -$signed({1'b0, r});
  assign spl_d  = $signed({dbfs_q[12], dbfs_q}) +
                  $signed({calib_offset_i[12], calib_offset_i});

  assign bar_d    = spl_q - 14'(rdlm_pkg::BAR_LOW);
  assign bar_prod = 19'(bar_d[11:0]) * 19'(rdlm_pkg::BAR_WIDTH);
  assign bar_pre  = 14'(bar_prod >> rdlm_pkg::BAR_PRE_SHIFT);
  assign bar_rcp  = 29'(bar_pre) * 29'(rdlm_pkg::BAR_RECIP);
  assign bar_val  = status_o.bar_skip ? 7'd0 :
                    (quo_q > 48'(rdlm_pkg::BAR_WIDTH)) ? 7'(rdlm_pkg::BAR_WIDTH) : quo_q[6:0];

  assign status_o.last      = !is_dc && (k_next >= {1'b0, window_i});
  assign status_o.div_done  = cnt_q == 6'(rdlm_pkg::DIV_STEPS - 1);
  assign status_o.norm_done = x_q[27] || (x_q == '0);
  assign status_o.sqr_done  = cnt_q == 6'(rdlm_pkg::SQR_STEPS - 1);
  assign status_o.bar_skip  = spl_q <= $signed(14'(rdlm_pkg::BAR_LOW));
  assign status_o.out_busy  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      dc_q        <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        rdlm_pkg::OP_SAMPLE: begin
          phase_q <= phase_inc;
          if (is_dc) dc_q <= dc_q + {4'b0000, sample_i};
          else sq_q <= sq_q + {20'd0, cen_sq[27:0]};
        end
        rdlm_pkg::OP_MS_LOAD: begin
          phase_q <= '0;
          dc_q    <= '0;
          sq_q    <= '0;
          cnt_q   <= '0;
        end
        rdlm_pkg::OP_DIV_STEP:  cnt_q <= cnt_q + 6'd1;
        rdlm_pkg::OP_NORM_STEP: if (status_o.norm_done) cnt_q <= '0;
        rdlm_pkg::OP_SQR_STEP:  cnt_q <= cnt_q + 6'd1;
        rdlm_pkg::OP_BAR_LOAD:  cnt_q <= '0;
        rdlm_pkg::OP_OUT_LOAD:  out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rdlm_pkg::OP_SAMPLE: begin
        k_q <= k_next[15:0];
      end
      rdlm_pkg::OP_MS_LOAD: begin
        rem_q <= '0;
        quo_q <= sq_q;
        dvs_q <= k_q;
      end
      rdlm_pkg::OP_DIV_STEP: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[46:0], rem_ge};
      end
      rdlm_pkg::OP_NORM_LOAD: begin
        ms_q <= quo_q[27:0];
        x_q  <= quo_q[27:0];
        n_q  <= 5'(rdlm_pkg::NORM_TOP);
      end
      rdlm_pkg::OP_NORM_STEP: begin
        if (status_o.norm_done) begin
          m_q    <= {x_q, 3'b000};
          frac_q <= '0;
        end else begin
          x_q <= {x_q[26:0], 1'b0};
          n_q <= n_q - 5'd1;
        end
      end
      rdlm_pkg::OP_SQR_STEP: begin
        if (mt[31]) begin
          m_q    <= mt[31:1];
          frac_q <= {frac_q[22:0], 1'b1};
        end else begin
          m_q    <= mt[30:0];
          frac_q <= {frac_q[22:0], 1'b0};
        end
      end
      rdlm_pkg::OP_MAG: begin
        mag_q <= (rdlm_pkg::LOG_FS > lms) ? (rdlm_pkg::LOG_FS - lms) : '0;
      end
      rdlm_pkg::OP_MUL: begin
        prod_q <= 59'(mag_q) * 59'(rdlm_pkg::LOG_K);
      end
      rdlm_pkg::OP_ROUND: begin
        dbfs_q <= dbfs_d;
        spl_q  <= $signed({dbfs_d[12], dbfs_d}) +
                  $signed({calib_offset_i[12], calib_offset_i});
      end
      rdlm_pkg::OP_BAR_LOAD: begin
        quo_q <= 48'(bar_rcp >> rdlm_pkg::BAR_RECIP_SHIFT);
      end
      rdlm_pkg::OP_OUT_LOAD: begin
        dbfs_level_o  <= dbfs_q;
        spl_level_o   <= spl_d;
        bar_fill_o    <= bar_val;
        calibrated_o  <= calib_valid_i;
        mean_square_o <= ms_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- src/rms_decibel_level_meter_top.sv -----
// ----------------------------------------------------------------------------
// RMS decibel level meter
// Windowed DC removal, mean square, dBFS, calibrated SPL and bar fill.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while a window is being collected.
// After the last sample of a window, input stalls while the 48-step divider, the
// normalize shifter and 24 squarings run.
// The result waits in an output register, and the stall grows only while the previous
// result is still unaccepted.
// Reset: registers return to defaults (window 600), the window restarts in DC phase.
`default_nettype none

module rms_decibel_level_meter_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [9:0]         sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [12:0]      dbfs_level_o,
  output logic signed [13:0]      spl_level_o,
  output logic [6:0]              bar_fill_o,
  output logic                    calibrated_o,
  output logic [27:0]             mean_square_o
);

  logic [15:0]        window_q;
  logic signed [12:0] calib_offset_q;
  logic               calib_valid_q;
  logic [15:0]        window_eff;

  rdlm_pkg::cmd_t    cmd;
  rdlm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;
  assign window_eff  = (window_q == '0) ? 16'd1 : window_q;
  assign in_ready_o  = cmd.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q       <= rdlm_pkg::WINDOW_RESET;
      calib_offset_q <= '0;
      calib_valid_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rdlm_pkg::REG_WINDOW:      window_q <= cfg_data_i;
        rdlm_pkg::REG_CALIB_OFFS:  calib_offset_q <= $signed(cfg_data_i[12:0]);
        rdlm_pkg::REG_CALIB_VALID: calib_valid_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rdlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdlm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (sample_i),
    .window_i       (window_eff),
    .calib_offset_i (calib_offset_q),
    .calib_valid_i  (calib_valid_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dbfs_level_o   (dbfs_level_o),
    .spl_level_o    (spl_level_o),
    .bar_fill_o     (bar_fill_o),
    .calibrated_o   (calibrated_o),
    .mean_square_o  (mean_square_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// RMS decibel level meter testbench
// Streams windows of microphone samples through the meter and checks each
// window result (mean square, dBFS, SPL, bar fill, calibrated flag) against
// a cycle-free behavioral predictor, under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 220;
  localparam int CYCLE_LIMIT   = 1_000_000;

  localparam int SHAPE_SILENT = 0;
  localparam int SHAPE_NOISE  = 1;
  localparam int SHAPE_RANDOM = 2;
  localparam int SHAPE_SQUARE = 3;
  localparam int SHAPE_STEP   = 4;

  typedef struct packed {
    logic signed [12:0] dbfs;
    logic signed [13:0] spl;
    logic [6:0]         bar;
    logic               calib;
    logic [27:0]        ms;
  } level_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = rdlm_pkg::REG_WINDOW;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [9:0]  sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [12:0] dbfs_level_o;
  logic signed [13:0] spl_level_o;
  logic [6:0]  bar_fill_o;
  logic        calibrated_o;
  logic [27:0] mean_square_o;

  rms_decibel_level_meter_top u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [9:0] sample_q[$];
  level_t     level_q[$];
  bit         quiet = 1'b0;
  bit         failed = 1'b0;
  int         gap = 0;
  int         stall = 0;
  int         n_items = 0;
  int         n_levels = 0;
  int         n_cycles = 0;

  // meter copy
  logic [15:0]        m_window = rdlm_pkg::WINDOW_RESET;
  logic signed [12:0] m_offset = '0;
  logic               m_valid = 1'b0;
  int unsigned        m_count = 0;
  logic [13:0]        m_dc = '0;
  logic [47:0]        m_sq = '0;

  function automatic logic [63:0] log2_fixed(input logic [63:0] x);
    logic [63:0] mant;
    logic [63:0] fr;
    int top;
    top = 0;
    fr = '0;
    for (int b = 0; b < 64; b++) if (x[b]) top = b;
    mant = (top >= 30) ? (x >> (top - 30)) : (x << (30 - top));
    for (int b = 0; b < 24; b++) begin
      mant = (mant * mant) >> 30;
      fr = fr << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        fr[0] = 1'b1;
      end
    end
    return (64'(top) << 24) | fr;
  endfunction

  function automatic int dbfs_of(input logic [63:0] ms);
    logic [63:0] fs;
    logic [63:0] lf;
    logic [63:0] lm;
    logic [63:0] diff;
    logic [63:0] r;
    fs = 64'(1023 * 16) * 64'(1023 * 16);
    if (ms == 0) return -2144;
    lf = log2_fixed(fs);
    lm = log2_fixed(ms);
    diff = (lf > lm) ? lf - lm : 64'd0;
    r = (diff * 64'd808071242 + (64'd1 << 47)) >> 48;
    if (r > 64'd2144) return -2144;
    return -int'(r);
  endfunction

  task automatic take_sample(input logic [9:0] s);
    longint c;
    int unsigned w;
    int unsigned k;
    logic [63:0] ms;
    int db;
    int spl;
    int bar;
    level_t lv;
    w = (m_window == 0) ? 1 : m_window;
    if (m_count < 16) begin
      m_dc = m_dc + s;
      m_count++;
      return;
    end
    c = longint'(s) * 16 - longint'(m_dc);
    m_sq = m_sq + 48'(c * c);
    m_count++;
    k = m_count - 16;
    if (k < w) return;
    ms = 64'(m_sq) / 64'(k);
    db = dbfs_of(ms);
    spl = db + int'(m_offset);
    if (spl <= 480) bar = 0;
    else begin
      bar = ((spl - 480) * 116) / 1440;
      if (bar > 116) bar = 116;
    end
    lv.dbfs = 13'(db);
    lv.spl = 14'(spl);
    lv.bar = 7'(bar);
    lv.calib = m_valid;
    lv.ms = ms[27:0];
    level_q.push_back(lv);
    m_count = 0;
    m_dc = '0;
    m_sq = '0;
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        gap <= gap - 1;
      end else if (sample_q.size() != 0) begin
        in_valid_i <= 1'b1;
        sample_i <= sample_q.pop_front();
        gap <= quiet ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor, output stall and prediction
  always @(posedge clk_i or negedge rst_ni) begin
    int s;
    level_t lv;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_levels++;
        if (level_q.size() == 0) begin
          $error("result with no expectation");
          failed = 1'b1;
        end else begin
          lv = level_q.pop_front();
          if (dbfs_level_o !== lv.dbfs) begin
            $error("dbfs_level exp %0d got %0d", lv.dbfs, dbfs_level_o);
            failed = 1'b1;
          end
          if (spl_level_o !== lv.spl) begin
            $error("spl_level exp %0d got %0d", lv.spl, spl_level_o);
            failed = 1'b1;
          end
          if (bar_fill_o !== lv.bar) begin
            $error("bar_fill exp %0d got %0d", lv.bar, bar_fill_o);
            failed = 1'b1;
          end
          if (calibrated_o !== lv.calib) begin
            $error("calibrated exp %0d got %0d", lv.calib, calibrated_o);
            failed = 1'b1;
          end
          if (mean_square_o !== lv.ms) begin
            $error("mean_square exp %0d got %0d", lv.ms, mean_square_o);
            failed = 1'b1;
          end
        end
        s = quiet ? 0 : $urandom_range(0, 15);
        stall <= s;
        out_ready_i <= (s == 0);
      end else if (stall != 0) begin
        stall <= stall - 1;
        out_ready_i <= (stall == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
      if (in_valid_i && in_ready_o) take_sample(sample_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rdlm_pkg::REG_WINDOW:      m_window = cfg_data_i;
          rdlm_pkg::REG_CALIB_OFFS:  m_offset = cfg_data_i[12:0];
          rdlm_pkg::REG_CALIB_VALID: m_valid = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_meter(input int win, input int offs, input bit cv);
    write_reg(rdlm_pkg::REG_WINDOW, 16'(win));
    write_reg(rdlm_pkg::REG_CALIB_OFFS, 16'(offs));
    write_reg(rdlm_pkg::REG_CALIB_VALID, 16'(cv));
  endtask

  task automatic wait_drain();
    while (sample_q.size() != 0 || in_valid_i || level_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [9:0] shaped(input int shape, input int i, input logic [9:0] mid);
    case (shape)
      SHAPE_SILENT: return mid;
      SHAPE_NOISE:  return 10'(int'(mid) + $urandom_range(0, 8));
      SHAPE_SQUARE: return i[0] ? 10'd1023 : 10'd0;
      SHAPE_STEP:   return (i < 16) ? 10'd0 : 10'd1023;
      default:      return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic push_window(input int shape, input int len);
    logic [9:0] mid;
    mid = 10'($urandom_range(0, 1015));
    for (int i = 0; i < 16 + len; i++) begin
      sample_q.push_back(shaped(shape, i, mid));
      n_items++;
    end
  endtask

  initial begin
    int win;
    int len;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    // directed: zero window, ceiling, silence, offset extremes
    set_meter(0, 3200, 1'b1);
    push_window(SHAPE_STEP, 1);
    push_window(SHAPE_SILENT, 1);
    wait_drain();
    set_meter(2, -3200, 1'b0);
    push_window(SHAPE_SQUARE, 2);
    push_window(SHAPE_RANDOM, 2);
    wait_drain();
    // window shortened while one is open
    set_meter(65535, 1200, 1'b1);
    for (int i = 0; i < 20; i++) begin
      sample_q.push_back(shaped(SHAPE_RANDOM, i, 10'd0));
      n_items++;
    end
    wait_drain();
    write_reg(rdlm_pkg::REG_WINDOW, 16'd3);
    sample_q.push_back(10'd1023);
    n_items++;
    wait_drain();

    while (n_items < 800) begin
      case ($urandom_range(0, 9))
        0:       win = 0;
        1:       win = $urandom_range(100, 300);
        default: win = $urandom_range(1, 24);
      endcase
      set_meter(win, $urandom_range(0, 6400) - 3200, 1'($urandom_range(0, 1)));
      len = (win == 0) ? 1 : win;
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 5) == 0) quiet = ~quiet;
        push_window($urandom_range(SHAPE_SILENT, SHAPE_STEP), len);
      end
      wait_drain();
    end

    $display("Covered %0d samples and %0d window results over zero, short, long and",
             n_items, n_levels);
    $display("shortened windows, silent to full-scale input, offsets at both limits.");
    if (!failed) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
